/* rtl/compact_datagram_header_parser_assert.svh */
// Assertion macros shared by the compact datagram header parser RTL.
`ifndef COMPACT_DATAGRAM_HEADER_PARSER_ASSERT_SVH
`define COMPACT_DATAGRAM_HEADER_PARSER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define CDHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define CDHP_ASSERT_NEVER(label, cond, msg) \
  `CDHP_ASSERT(label, !(cond), msg)

`endif

/* rtl/cdhp_pkg.sv */
// Types and constants of the compact datagram header parser.
`timescale 1ns / 1ps

package cdhp_pkg;

  localparam int unsigned BODY_COUNT_BITS_DEF = 16;
  localparam int unsigned OUT_FIFO_DEPTH = 4;

  localparam logic [3:0]  EXP_VERSION_RST = 4'd1;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam logic [2:0] POS_VERSION = 3'd0;
  localparam logic [2:0] POS_OP      = 3'd1;
  localparam logic [2:0] POS_SEQ_HI  = 3'd2;
  localparam logic [2:0] POS_SEQ_LO  = 3'd3;
  localparam logic [2:0] POS_EPOCH   = 3'd4;
  localparam logic [2:0] POS_BODY    = 3'd5;

  localparam logic KIND_BODY    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_MALFORMED   = 2'd1,
    STATUS_UNSUPPORTED = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  body_byte;
    status_e     status;
    logic [7:0]  op_code;
    logic [15:0] sequence_res;
    logic        epoch_present;
    logic [7:0]  epoch_value;
    logic [15:0] body_length;
    logic        final_result;
  } out_word_t;

endpackage

/* rtl/compact_datagram_header_parser.sv */
// Compact datagram header parser: header capture, body pass-through, summary queue.
// Result words are registered in the output queue before they are offered.
// Throughput: one byte per cycle while in_stall_o is low; a last byte that is body queues two words.
// The four-entry output queue takes new bytes while two entries are free.
// Reset clears frame state and the queue and sets the expected version to 1.
// The first byte after reset or after a last byte is header byte 0.
`timescale 1ns / 1ps
`include "compact_datagram_header_parser_assert.svh"

module compact_datagram_header_parser #(
  parameter int unsigned BODY_COUNT_BITS = cdhp_pkg::BODY_COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cdhp_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cdhp_pkg::out_word_t  out_word_o
);
  import cdhp_pkg::*;

  localparam int unsigned PtrW  = $clog2(OUT_FIFO_DEPTH);
  localparam int unsigned CntW  = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int unsigned WideW = (BODY_COUNT_BITS > 16) ? BODY_COUNT_BITS : 16;

  logic [3:0]                 exp_ver_q;
  logic [2:0]                 pos_q, pos_d;
  logic                       vgood_q, vgood_d;
  logic                       eflag_q, eflag_d;
  logic [7:0]                 op_q, op_d;
  logic [15:0]                seq_q, seq_d;
  logic [7:0]                 epoch_q, epoch_d;
  logic [BODY_COUNT_BITS-1:0] bcnt_q, bcnt_d;

  logic                       in_acc, out_acc;
  logic                       body_hit, push2;
  logic [BODY_COUNT_BITS-1:0] bcnt_next;
  logic [WideW-1:0]           bcnt_wide;
  logic [15:0]                shown_len;
  logic [3:0]                 len;
  status_e                    status;
  out_word_t                  body_word, sum_word, first_word;

  out_word_t                  fifo_q [OUT_FIFO_DEPTH];
  logic [PtrW-1:0]            wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]            fcnt_q;
  logic [CntW-1:0]            push_n;

  assign in_stall_o  = (fcnt_q > CntW'(OUT_FIFO_DEPTH - 2));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (fcnt_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_word_o  = fifo_q[rd_ptr_q];

  always_comb begin
    body_hit  = vgood_q && ((pos_q == POS_EPOCH && !eflag_q) || pos_q == POS_BODY);
    bcnt_next = (body_hit && !(&bcnt_q)) ? bcnt_q + BODY_COUNT_BITS'(1) : bcnt_q;
    bcnt_wide = WideW'(bcnt_next);
    shown_len = (bcnt_wide > WideW'(LEN_MAX)) ? LEN_MAX : bcnt_wide[15:0];
    len       = {1'b0, pos_q} + 4'd1;

    vgood_d = vgood_q;
    eflag_d = eflag_q;
    op_d    = op_q;
    seq_d   = seq_q;
    epoch_d = epoch_q;
    case (pos_q)
      POS_VERSION: begin
        vgood_d = (in_word_i.data_byte[7:4] == exp_ver_q);
        eflag_d = in_word_i.data_byte[0];
      end
      POS_OP:     op_d = in_word_i.data_byte;
      POS_SEQ_HI: seq_d = {in_word_i.data_byte, seq_q[7:0]};
      POS_SEQ_LO: seq_d = {seq_q[15:8], in_word_i.data_byte};
      POS_EPOCH: begin
        if (eflag_q) begin
          epoch_d = in_word_i.data_byte;
        end
      end
      default: ;
    endcase
    pos_d  = (pos_q == POS_BODY) ? POS_BODY : pos_q + 3'd1;
    bcnt_d = bcnt_next;

    if (len < 4'd4) begin
      status = STATUS_MALFORMED;
    end else if (!vgood_d) begin
      status = STATUS_UNSUPPORTED;
    end else if (eflag_d && len < 4'd5) begin
      status = STATUS_MALFORMED;
    end else begin
      status = STATUS_OK;
    end

    body_word              = '0;
    body_word.kind         = KIND_BODY;
    body_word.body_byte    = in_word_i.data_byte;
    body_word.body_length  = shown_len;

    sum_word               = '0;
    sum_word.kind          = KIND_SUMMARY;
    sum_word.status        = status;
    sum_word.final_result  = 1'b1;
    if (status == STATUS_OK) begin
      sum_word.op_code       = op_d;
      sum_word.sequence_res  = seq_d;
      sum_word.epoch_present = eflag_d;
      sum_word.epoch_value   = eflag_d ? epoch_d : 8'd0;
      sum_word.body_length   = shown_len;
    end

    first_word = body_hit ? body_word : sum_word;
    push2      = body_hit && in_word_i.last_byte;
    push_n     = in_acc ? (CntW'(body_hit) + CntW'(in_word_i.last_byte)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ver_q <= EXP_VERSION_RST;
      pos_q     <= POS_VERSION;
      vgood_q   <= 1'b0;
      eflag_q   <= 1'b0;
      op_q      <= '0;
      seq_q     <= '0;
      epoch_q   <= '0;
      bcnt_q    <= '0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      fcnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        exp_ver_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        if (in_word_i.last_byte) begin
          pos_q   <= POS_VERSION;
          vgood_q <= 1'b0;
          eflag_q <= 1'b0;
          op_q    <= '0;
          seq_q   <= '0;
          epoch_q <= '0;
          bcnt_q  <= '0;
        end else begin
          pos_q   <= pos_d;
          vgood_q <= vgood_d;
          eflag_q <= eflag_d;
          op_q    <= op_d;
          seq_q   <= seq_d;
          epoch_q <= epoch_d;
          bcnt_q  <= bcnt_d;
        end
      end
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      fcnt_q <= fcnt_q + push_n - CntW'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != '0) begin
      fifo_q[wr_ptr_q] <= first_word;
      if (push2) begin
        fifo_q[PtrW'(wr_ptr_q + PtrW'(1))] <= sum_word;
      end
    end
  end

  `CDHP_ASSERT_NEVER(a_fifo_over, fcnt_q > CntW'(OUT_FIFO_DEPTH), "output queue overflow")
  `CDHP_ASSERT(a_room_on_accept, in_acc |-> fcnt_q <= CntW'(OUT_FIFO_DEPTH - 2), "no room")
  `CDHP_ASSERT_NEVER(a_pos_range, pos_q > POS_BODY, "byte position beyond body")
  `CDHP_ASSERT(a_restart, in_acc && in_word_i.last_byte |=> pos_q == POS_VERSION, "no restart")
  `CDHP_ASSERT(a_final, out_valid_o |-> out_word_o.kind == out_word_o.final_result, "final flag")

endmodule
